/* rtl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, types and codes of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int VAL_W    = 31;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    val_t    result_value;
    status_e status;
  } result_t;

  // one-based heap position to memory index
  function automatic addr_t pos2idx(pos_t p);
    pos_t d;
    d = p - pos_t'(1);
    return d[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/mhpq_if.sv */
// ----------------------------------------------------------------------------
// mhpq_if
// Valid/ready channels of the max-heap priority queue.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  import mhpq_pkg::*;

  logic valid;
  logic ready;
  logic command;
  val_t value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mhpq_out_if;
  import mhpq_pkg::*;

  logic    valid;
  logic    ready;
  val_t    result_value;
  status_e status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

/* rtl/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// Synchronous RAM, one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int Depth = 1024,
  parameter int Width = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

/* rtl/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Heap sequencer: entry count, sift-up and sift-down over the heap RAM.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  mhpq_in_if.sink           in_i,
  output logic              res_valid_o,
  output mhpq_pkg::result_t res_o,
  input  logic              res_free_i,
  output logic              we_o,
  output mhpq_pkg::addr_t   waddr_o,
  output mhpq_pkg::val_t    wdata_o,
  output mhpq_pkg::addr_t   raddr0_o,
  output mhpq_pkg::addr_t   raddr1_o,
  input  mhpq_pkg::val_t    rdata0_i,
  input  mhpq_pkg::val_t    rdata1_i
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UP,
    S_DOWN,
    S_EMIT
  } state_e;

  state_e    state_q, state_d;
  pos_t      count_q, count_d;
  pos_t      pos_q, pos_d;
  val_t      val_q, val_d;
  result_t   res_q, res_d;

  pos_t          count_inc;
  logic [POS_W:0] left_pos;
  logic          right_ok;
  logic          take_right;
  val_t          child_val;
  pos_t          child_pos;
  logic [POS_W:0] grand_pos;

  assign count_inc  = count_q + pos_t'(1);
  assign left_pos   = {pos_q, 1'b0};
  assign right_ok   = left_pos < {1'b0, count_q};
  assign take_right = right_ok && (rdata0_i < rdata1_i);
  assign child_val  = take_right ? rdata1_i : rdata0_i;
  assign child_pos  = take_right ? (left_pos[POS_W-1:0] + pos_t'(1)) : left_pos[POS_W-1:0];
  assign grand_pos  = {child_pos, 1'b0};

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    val_d    = val_q;
    res_d    = res_q;
    we_o     = 1'b0;
    waddr_o  = pos2idx(pos_q);
    wdata_o  = val_q;
    raddr0_o = '0;
    raddr1_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.command == CMD_INSERT) begin
            if (count_q == pos_t'(CAPACITY)) begin
              res_d   = '{result_value: '0, status: ST_FULL};
              state_d = S_EMIT;
            end else begin
              res_d   = '{result_value: '0, status: ST_OK};
              count_d = count_inc;
              pos_d   = count_inc;
              val_d   = in_i.value;
              if (count_q == '0) begin
                we_o    = 1'b1;
                waddr_o = '0;
                wdata_o = in_i.value;
                state_d = S_EMIT;
              end else begin
                raddr0_o = pos2idx(count_inc >> 1);
                state_d  = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_d   = '{result_value: '0, status: ST_EMPTY};
              state_d = S_EMIT;
            end else begin
              count_d  = count_q - pos_t'(1);
              raddr0_o = '0;
              raddr1_o = pos2idx(count_q);
              state_d  = S_ROOT;
            end
          end
        end
      end
      S_ROOT: begin
        res_d = '{result_value: rdata0_i, status: ST_OK};
        val_d = rdata1_i;
        pos_d = pos_t'(1);
        if (count_q == '0) begin
          state_d = S_EMIT;
        end else begin
          raddr0_o = pos2idx(pos_t'(2));
          raddr1_o = pos2idx(pos_t'(3));
          state_d  = S_DOWN;
        end
      end
      S_UP: begin
        we_o = 1'b1;
        if (pos_q == pos_t'(1) || val_q <= rdata0_i) begin
          state_d = S_EMIT;
        end else begin
          wdata_o  = rdata0_i;
          pos_d    = pos_q >> 1;
          raddr0_o = pos2idx(pos_q >> 2);
        end
      end
      S_DOWN: begin
        we_o = 1'b1;
        if (left_pos > {1'b0, count_q} || child_val <= val_q) begin
          state_d = S_EMIT;
        end else begin
          wdata_o  = child_val;
          pos_d    = child_pos;
          raddr0_o = addr_t'(grand_pos - 1'b1);
          raddr1_o = addr_t'(grand_pos);
        end
      end
      S_EMIT: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    res_q <= res_d;
  end

endmodule

/* rtl/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue held in a dual-read synchronous RAM.
//
//   channel  dir  payload                      handshake
//   in_i     in   command, value               valid/ready
//   out_o    out  result_value, status         valid/ready
//
// Insert sifts the new value up and remove sifts the last entry down from
// the root, with one RAM access round per heap level visited.
// Reset clears the entry count; the heap RAM is not cleared.
// Input is taken only between items; an output register lets the next
// item start while the last result waits.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  mhpq_in_if.sink   in_i,
  mhpq_out_if.source out_o
);
  import mhpq_pkg::*;

  logic    we;
  addr_t   waddr;
  val_t    wdata;
  addr_t   raddr0;
  addr_t   raddr1;
  val_t    rdata0;
  val_t    rdata1;
  logic    res_valid;
  result_t res;
  logic    res_free;

  logic    out_valid_q;
  result_t out_q;

  mhpq_ram #(
    .Depth (CAPACITY),
    .Width (VAL_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr0_o    (raddr0),
    .raddr1_o    (raddr1),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1)
  );

  assign res_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_q.result_value;
  assign out_o.status       = out_q.status;

endmodule
